/* hw/rtl/dfr_pkg.sv */
package dfr_pkg;

  localparam int BYTE_W            = 8;
  localparam int MAX_PAYLOAD_BYTES = 8;
  localparam int PAYLOAD_W         = MAX_PAYLOAD_BYTES * BYTE_W;
  localparam int NUM_KINDS         = 6;
  localparam int KIND_W            = 3;
  localparam int COUNT_W           = 4;
  localparam int LEN_W             = 16;
  localparam int CFG_IDX_W         = 8;

  // Kind codes: null, command, switches, infrared, inertial, wheel encoder
  localparam logic [KIND_W-1:0] KIND_NULL = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NONE = 3'd6;

  localparam logic [COUNT_W-1:0] POS_LEN_HI  = 4'd1;
  localparam logic [COUNT_W-1:0] POS_LEN_LO  = 4'd2;
  localparam logic [COUNT_W-1:0] POS_TYPE    = 4'd3;
  localparam logic [COUNT_W-1:0] POS_PAYLOAD = 4'd4;

  // Payload size of each kind, in bytes
  localparam logic [COUNT_W-1:0] KIND_SIZE [NUM_KINDS] = '{
    4'd0, 4'd4, 4'd1, 4'd5, 4'd6, 4'd8
  };

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_MARKER   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_MARKER    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_NULL      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_COMMAND   = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_SWITCHES  = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_INFRARED  = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_INERTIAL  = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_ENCODER   = 8'd7;

  typedef struct packed {
    logic [BYTE_W-1:0]                 start_marker;
    logic [BYTE_W-1:0]                 stop_marker;
    logic [NUM_KINDS-1:0][BYTE_W-1:0]  codes;  // indexed by kind
  } cfg_t;

  // First matching code wins, in kind order
  function automatic logic [KIND_W-1:0] lookup_kind(input cfg_t cfg,
                                                    input logic [BYTE_W-1:0] b);
    logic [KIND_W-1:0] k;
    k = KIND_NONE;
    for (int i = NUM_KINDS - 1; i >= 0; i--) begin
      if (cfg.codes[i] == b) begin
        k = KIND_W'(i);
      end
    end
    return k;
  endfunction

endpackage

/* hw/rtl/dfr_cfg_regs.sv */
module dfr_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dfr_pkg::BYTE_W-1:0]      cfg_data,
  output dfr_pkg::cfg_t                   cfg
);
  import dfr_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_marker <= 8'd2;
      cfg.stop_marker  <= 8'd3;
      cfg.codes[0]     <= 8'd0;
      cfg.codes[1]     <= 8'd1;
      cfg.codes[2]     <= 8'd2;
      cfg.codes[3]     <= 8'd3;
      cfg.codes[4]     <= 8'd4;
      cfg.codes[5]     <= 8'd5;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_START_MARKER:  cfg.start_marker <= cfg_data;
        REG_STOP_MARKER:   cfg.stop_marker  <= cfg_data;
        REG_CODE_NULL:     cfg.codes[0]     <= cfg_data;
        REG_CODE_COMMAND:  cfg.codes[1]     <= cfg_data;
        REG_CODE_SWITCHES: cfg.codes[2]     <= cfg_data;
        REG_CODE_INFRARED: cfg.codes[3]     <= cfg_data;
        REG_CODE_INERTIAL: cfg.codes[4]     <= cfg_data;
        REG_CODE_ENCODER:  cfg.codes[5]     <= cfg_data;
        default: ;  // unknown index: dropped
      endcase
    end
  end

endmodule

/* hw/rtl/dfr_in_reg.sv */
module dfr_in_reg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [dfr_pkg::BYTE_W-1:0]  rx_byte,
  input  logic                        advance,
  output logic                        item_valid,
  output logic [dfr_pkg::BYTE_W-1:0]  item_byte
);
  import dfr_pkg::*;

  // held item blocks the input only while the parser cannot take it
  assign in_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_byte <= rx_byte;
    end
  end

endmodule

/* hw/rtl/dfr_parser.sv */
module dfr_parser (
  input  logic                            clk,
  input  logic                            rst,
  input  dfr_pkg::cfg_t                   cfg,
  input  logic                            item_valid,
  input  logic [dfr_pkg::BYTE_W-1:0]      item_byte,
  output logic                            advance,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [dfr_pkg::KIND_W-1:0]      frame_type,
  output logic [dfr_pkg::COUNT_W-1:0]     payload_length,
  output logic [dfr_pkg::PAYLOAD_W-1:0]   payload
);
  import dfr_pkg::*;

  logic                  in_frame, in_frame_next;
  logic [COUNT_W-1:0]    byte_count, byte_count_next;
  logic [LEN_W-1:0]      declared_length, declared_length_next;
  logic [KIND_W-1:0]     frame_kind, frame_kind_next;
  logic [PAYLOAD_W-1:0]  payload_store, payload_store_next;
  logic [KIND_W-1:0]     kind;
  logic [COUNT_W-1:0]    idx;
  logic [LEN_W-1:0]      idx_ext;
  logic                  emit;

  assign advance = !out_valid || !out_stall;

  always_comb begin
    in_frame_next        = in_frame;
    byte_count_next      = byte_count;
    declared_length_next = declared_length;
    frame_kind_next      = frame_kind;
    payload_store_next   = payload_store;
    emit                 = 1'b0;
    kind                 = lookup_kind(cfg, item_byte);
    idx                  = byte_count - POS_PAYLOAD;
    idx_ext              = LEN_W'(idx);

    if (!in_frame) begin
      if (item_byte == cfg.start_marker) begin
        in_frame_next        = 1'b1;
        byte_count_next      = POS_LEN_HI;
        declared_length_next = '0;
      end
    end else begin
      case (byte_count)
        POS_LEN_HI: begin
          declared_length_next = {item_byte, 8'h00};
          byte_count_next      = POS_LEN_LO;
        end
        POS_LEN_LO: begin
          declared_length_next = declared_length | LEN_W'(item_byte);
          byte_count_next      = POS_TYPE;
        end
        POS_TYPE: begin
          if (kind == KIND_NONE ||
              declared_length != LEN_W'(KIND_SIZE[kind])) begin
            in_frame_next   = 1'b0;
            byte_count_next = '0;
          end else begin
            frame_kind_next    = kind;
            payload_store_next = '0;
            byte_count_next    = POS_PAYLOAD;
          end
        end
        default: begin
          if (item_byte == cfg.stop_marker && idx_ext == declared_length) begin
            in_frame_next   = 1'b0;
            byte_count_next = '0;
            emit            = (frame_kind != KIND_NULL);
          end else if (idx_ext > declared_length) begin
            // trailer was wrong one byte ago: drop the frame
            in_frame_next   = 1'b0;
            byte_count_next = '0;
          end else begin
            if (idx_ext < declared_length) begin
              payload_store_next = {payload_store[PAYLOAD_W-BYTE_W-1:0], item_byte};
            end
            byte_count_next = byte_count + 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      byte_count <= '0;
      out_valid  <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid && emit;
      if (item_valid) begin
        in_frame   <= in_frame_next;
        byte_count <= byte_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid) begin
      declared_length <= declared_length_next;
      frame_kind      <= frame_kind_next;
      payload_store   <= payload_store_next;
      if (emit) begin
        frame_type     <= frame_kind - 1'b1;
        payload_length <= declared_length[COUNT_W-1:0];
        payload        <= payload_store;
      end
    end
  end

endmodule

/* hw/rtl/framed_sensor_packet_deframer.sv */
// Framed sensor packet deframer: start / length / type / payload / stop.
// Throughput: one byte per cycle; a stalled result lets one more byte into the input register.
// Latency: an accepted stop byte passes the input register, then the parse logic into
// the result register, which loads once the result is not stalled.
// Synchronous reset returns the parser to idle, empties both registers and
// loads the default markers and type codes.
module framed_sensor_packet_deframer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [dfr_pkg::BYTE_W-1:0]      rx_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [dfr_pkg::KIND_W-1:0]      frame_type,
  output logic [dfr_pkg::COUNT_W-1:0]     payload_length,
  output logic [dfr_pkg::PAYLOAD_W-1:0]   payload,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dfr_pkg::BYTE_W-1:0]      cfg_data
);
  import dfr_pkg::*;

  cfg_t              cfg;
  logic              advance;
  logic              item_valid;
  logic [BYTE_W-1:0] item_byte;

  dfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dfr_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .advance    (advance),
    .item_valid (item_valid),
    .item_byte  (item_byte)
  );

  dfr_parser u_parse (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .item_valid     (item_valid),
    .item_byte      (item_byte),
    .advance        (advance),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .frame_type     (frame_type),
    .payload_length (payload_length),
    .payload        (payload)
  );

endmodule

/* hw/rtl/dfr_checker.sv */
module dfr_protocol_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [dfr_pkg::KIND_W-1:0]      frame_type,
  input logic [dfr_pkg::COUNT_W-1:0]     payload_length,
  input logic [dfr_pkg::PAYLOAD_W-1:0]   payload
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(payload) && $stable(frame_type))
    else $error("stalled result changed");

  // only sized kinds reach the output
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> frame_type <= 3'd4 && payload_length != 4'd0 &&
                  payload_length <= 4'd8)
    else $error("result type or length out of range");

  // a fresh result follows a byte taken by the input register
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a byte behind it");

endmodule

bind framed_sensor_packet_deframer dfr_protocol_chk u_chk (.*);
